// File: design/utf8d_pkg.sv
// Shared types for the UTF-8 byte stream decoder.
// Item and result layouts, result kinds and lead byte constants; no dependencies.
package utf8d_pkg;

  typedef enum logic [1:0] {
    KIND_CODE     = 2'd0,
    KIND_END      = 2'd1,
    KIND_NOTUTF8  = 2'd2,
    KIND_UPSTREAM = 2'd3
  } kind_t;

  typedef struct packed {
    logic       upstream_fault;
    logic       stream_ended;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [30:0] code_point;
  } res_t;

  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] PAY_MASK6  = 8'h3F;
  localparam logic [7:0] LEAD2_MASK = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'h07;
  localparam logic [7:0] LEAD5_MASK = 8'h03;
  localparam logic [7:0] LEAD6_MASK = 8'h01;

endpackage

// File: design/utf8_byte_stream_decoder_unit.sv
// Top level of the UTF-8 byte stream decoder: input skid, decode step, result register.
// Depends on utf8d_pkg, utf8d_skid and utf8d_core.
//
// Decodes legacy UTF-8 (one to six byte sequences) one byte per beat and gives one
// result beat when a sequence completes, on a clean end, or on an error; a decode or
// upstream error is sticky until reset. Throughput is one byte per cycle while the
// receiver takes results; a stalled result holds the input back. Each input beat
// waits in the item register, then the single decode step writes the result register.
module utf8_byte_stream_decoder_unit import utf8d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [0] stream_ended, [1] upstream_fault
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [30:0] code_point, [31] zero
  output logic [1:0]  out_tuser   // [1:0] result_kind
);

  item_t in_item;
  item_t main_item;
  logic  main_valid;
  logic  skid_full;
  logic  pop;
  logic  out_free;
  logic  has_res;
  res_t  res;
  kind_t err_status;

  logic  out_valid_r, out_valid_nxt;
  res_t  out_r, out_nxt;

  assign in_item.data_byte      = in_tdata;
  assign in_item.stream_ended   = in_tuser[0];
  assign in_item.upstream_fault = in_tuser[1];

  assign out_free = !out_valid_r || out_tready;
  assign pop      = main_valid && out_free;

  utf8d_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .pop        (pop),
    .main_valid (main_valid),
    .main_item  (main_item),
    .skid_full  (skid_full)
  );

  utf8d_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (pop),
    .item       (main_item),
    .has_res    (has_res),
    .res        (res),
    .err_status (err_status)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (pop) begin
      out_valid_nxt = has_res;
      out_nxt       = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.code_point};
  assign out_tuser  = out_r.result_kind;

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_status != KIND_CODE) |=> $stable(err_status))
    else $error("sticky error changed");

  a_skid_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full |-> (out_valid_r && main_valid))
    else $error("skid entry held without a stalled result");

  a_err_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.result_kind != KIND_CODE) |-> (out_r.code_point == '0))
    else $error("non-code result carries a code point");

  a_err_gives_err: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && err_status != KIND_CODE) |=> (out_valid_r && out_r.result_kind == $past(err_status)))
    else $error("latched error did not produce an error result");
`endif

endmodule

// File: design/utf8d_skid.sv
// Input item register with a skid entry, so input ready comes from a flop.
// Depends on utf8d_pkg for the item layout.
module utf8d_skid import utf8d_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  pop,
  output logic  main_valid,
  output item_t main_item,
  output logic  skid_full
);

  logic  main_valid_r, main_valid_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  item_t main_r, main_nxt;
  item_t skid_r, skid_nxt;
  logic  accept;

  assign in_ready   = !skid_valid_r;
  assign accept     = in_valid && in_ready;
  assign main_valid = main_valid_r;
  assign main_item  = main_r;
  assign skid_full  = skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = in_item;
        main_valid_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt       = in_item;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// File: design/utf8d_core.sv
// Decoder state (sticky error, bytes left, partial value) and the per-byte step.
// Depends on utf8d_pkg for item, result and kind types.
module utf8d_core import utf8d_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  item_t item,
  output logic  has_res,
  output res_t  res,
  output kind_t err_status
);

  kind_t       err_r, err_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic [30:0] part_r, part_nxt;
  logic [7:0]  b;
  logic [30:0] shifted;

  assign b          = item.data_byte;
  assign shifted    = {part_r[24:0], b[5:0]};
  assign err_status = err_r;

  always_comb begin
    err_nxt         = err_r;
    rem_nxt         = rem_r;
    part_nxt        = part_r;
    has_res         = 1'b0;
    res.code_point  = '0;
    res.result_kind = KIND_CODE;
    if (err_r != KIND_CODE) begin
      has_res         = 1'b1;
      res.result_kind = err_r;
    end else if (rem_r != 3'd0) begin
      if (item.stream_ended || ((b & CONT_MASK) != CONT_TAG)) begin
        has_res         = 1'b1;
        res.result_kind = KIND_NOTUTF8;
        err_nxt         = KIND_NOTUTF8;
        rem_nxt         = 3'd0;
        part_nxt        = '0;
      end else begin
        rem_nxt = rem_r - 3'd1;
        if (rem_r == 3'd1) begin
          has_res        = 1'b1;
          res.code_point = shifted;
          part_nxt       = '0;
        end else begin
          part_nxt = shifted;
        end
      end
    end else if (item.stream_ended) begin
      has_res = 1'b1;
      if (item.upstream_fault) begin
        res.result_kind = KIND_UPSTREAM;
        err_nxt         = KIND_UPSTREAM;
      end else begin
        res.result_kind = KIND_END;
      end
    end else if (b <= ASCII_MAX) begin
      has_res        = 1'b1;
      res.code_point = {23'd0, b};
    end else if (b[7:5] == 3'b110) begin
      part_nxt = {23'd0, b & LEAD2_MASK};
      rem_nxt  = 3'd1;
    end else if (b[7:4] == 4'b1110) begin
      part_nxt = {23'd0, b & LEAD3_MASK};
      rem_nxt  = 3'd2;
    end else if (b[7:3] == 5'b11110) begin
      part_nxt = {23'd0, b & LEAD4_MASK};
      rem_nxt  = 3'd3;
    end else if (b[7:2] == 6'b111110) begin
      part_nxt = {23'd0, b & LEAD5_MASK};
      rem_nxt  = 3'd4;
    end else if (b[7:1] == 7'b1111110) begin
      part_nxt = {23'd0, b & LEAD6_MASK};
      rem_nxt  = 3'd5;
    end else begin
      has_res         = 1'b1;
      res.result_kind = KIND_NOTUTF8;
      err_nxt         = KIND_NOTUTF8;
      part_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r  <= KIND_CODE;
      rem_r  <= 3'd0;
      part_r <= '0;
    end else if (step) begin
      err_r  <= err_nxt;
      rem_r  <= rem_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

// File: test/utf8_byte_stream_decoder_checker.sv
// Checker for the UTF-8 byte stream decoder: watches both streams, predicts each result
// beat from the accepted input beats and compares it with what the block gives.
// Depends on utf8d_pkg.
module utf8_byte_stream_decoder_checker import utf8d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  res_t        due_q[$];
  res_t        want;
  kind_t       sticky;
  logic [2:0]  cont_left;
  logic [30:0] accum;

  task automatic latch_error(input kind_t kind, inout res_t r);
    sticky    = kind;
    cont_left = '0;
    accum     = '0;
    r.result_kind = kind;
  endtask

  task automatic decode_beat(input item_t it);
    res_t r;
    bit   hit;
    int   ones;
    r.code_point  = '0;
    r.result_kind = KIND_CODE;
    hit  = 1'b1;
    ones = 0;
    while (ones < 8 && it.data_byte[7 - ones]) ones++;
    if (sticky != KIND_CODE) begin
      r.result_kind = sticky;
    end else if (cont_left != 0) begin
      if (it.stream_ended || (it.data_byte & CONT_MASK) != CONT_TAG) begin
        latch_error(KIND_NOTUTF8, r);
      end else begin
        accum     = {accum[24:0], it.data_byte[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == 0) begin
          r.code_point = accum;
          accum        = '0;
        end else begin
          hit = 1'b0;
        end
      end
    end else if (it.stream_ended) begin
      if (it.upstream_fault) latch_error(KIND_UPSTREAM, r);
      else r.result_kind = KIND_END;
    end else if (it.data_byte <= ASCII_MAX) begin
      r.code_point = {23'd0, it.data_byte};
    end else if (ones == 1 || ones > 6) begin
      latch_error(KIND_NOTUTF8, r);
    end else begin
      accum     = {23'd0, it.data_byte & (8'hFF >> (ones + 1))};
      cont_left = 3'(ones - 1);
      hit       = 1'b0;
    end
    if (hit) due_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sticky     = KIND_CODE;
      cont_left  = '0;
      accum      = '0;
      fail_count = 0;
      due_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          $display("%0t: result beat with none due: got tdata=%h kind=%0d",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = due_q.pop_front();
          if (out_tdata !== {1'b0, want.code_point}) begin
            $display("%0t: code point mismatch: expected %h, got %h",
                     $time, {1'b0, want.code_point}, out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.result_kind) begin
            $display("%0t: result kind mismatch: expected %0d, got %0d",
                     $time, want.result_kind, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) decode_beat({in_tuser, in_tdata});
    end
    pending = due_q.size();
  end

endmodule

// File: test/utf8_byte_stream_decoder_unit_tb.sv
// Testbench top for utf8_byte_stream_decoder_unit: clock, reset, byte stimulus,
// receiver back-pressure, watchdog and verdict.
// Depends on utf8d_pkg, the decoder RTL and utf8_byte_stream_decoder_checker.
module utf8_byte_stream_decoder_unit_tb;
  import utf8d_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN       = 10;
  localparam int PHASE_BYTES = 300;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  int          fail_count;
  int          pending;

  int          in_idle_pct  = 0;
  int          out_idle_pct = 0;
  bit          hold_go      = 1'b0;
  bit          hold_done    = 1'b0;
  int          quiet_cycles = 0;

  logic [7:0]  warmup_bytes [0:21] = '{
    8'h00, 8'h7F,
    8'hC2, 8'h80,
    8'hEF, 8'hBF, 8'hBF,
    8'hF0, 8'h90, 8'h80, 8'h80,
    8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
    8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF
  };

  utf8_byte_stream_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  utf8_byte_stream_decoder_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // call at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.data_byte;
    in_tuser  <= {it.upstream_fault, it.stream_ended};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    logic f;
    f = 1'($urandom_range(1));
    send_item({f, 1'b0, b});
  endtask

  task automatic send_end(input logic fault);
    logic [7:0] d;
    d = 8'($urandom);
    send_item({fault, 1'b1, d});
  endtask

  task automatic send_lead(input int len);
    logic [7:0] prefix;
    logic [7:0] payload;
    prefix  = 8'hFF << (8 - len);
    payload = 8'($urandom);
    if (len == 1) send_byte(payload & ASCII_MAX);
    else send_byte(prefix | (payload & (8'hFF >> (len + 1))));
  endtask

  task automatic send_cont();
    logic [7:0] payload;
    payload = 8'($urandom);
    send_byte(CONT_TAG | (payload & PAY_MASK6));
  endtask

  task automatic send_char(output int nbytes);
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      send_end(1'b0);
      nbytes = 1;
    end else begin
      if (pick < 36) nbytes = 1;
      else if (pick < 56) nbytes = 2;
      else if (pick < 71) nbytes = 3;
      else if (pick < 83) nbytes = 4;
      else if (pick < 92) nbytes = 5;
      else nbytes = 6;
      send_lead(nbytes);
      repeat (nbytes - 1) send_cont();
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic break_stream();
    int         len;
    logic [7:0] b;
    len = $urandom_range(6, 2);
    case ($urandom_range(4))
      0: send_byte(CONT_TAG | (8'($urandom) & PAY_MASK6));
      1: send_byte(8'hFE | 8'($urandom_range(1)));
      2: begin
        send_lead(len);
        repeat ($urandom_range(len - 2)) send_cont();
        b = 8'($urandom);
        while ((b & CONT_MASK) == CONT_TAG) b = 8'($urandom);
        send_byte(b);
      end
      3: begin
        send_lead(len);
        repeat ($urandom_range(len - 2)) send_cont();
        send_end(1'($urandom_range(1)));
      end
      default: send_end(1'b1);
    endcase
  endtask

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  initial begin
    int n;
    int got;
    repeat (3) @(negedge clk);
    rst_n        <= 1'b1;
    in_idle_pct  = 24;
    out_idle_pct = 51;

    send_end(1'b0);
    foreach (warmup_bytes[i]) send_byte(warmup_bytes[i]);
    send_lead(6);
    repeat (5) send_byte(CONT_TAG);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct  = 24;
          out_idle_pct = 51;
          hold_go      = 1'b1;
        end
        1: begin
          in_idle_pct  = 51;
          out_idle_pct = 24;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      n = 0;
      while (n < PHASE_BYTES) begin
        send_char(got);
        n += got;
      end
      drain_results();
    end

    // latch the sticky error, then keep feeding noise
    break_stream();
    repeat (40) begin
      if ($urandom_range(3) == 0) send_end(1'($urandom_range(1)));
      else send_byte(8'($urandom));
    end

    drain_results();
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
